// File: hw/rtl/qdd_pkg.sv
package qdd_pkg;

   localparam int unsigned STEPS_PER_DETENT_DEF = 4;
   localparam int unsigned DETENTS_PER_TURN_DEF = 8;

   localparam int unsigned DEG_PER_TURN = 360;

   localparam int unsigned POS_W = 4;
   localparam int unsigned DEG_W = 9;

   localparam logic [1:0] PINS_AT_RESET = 2'b11;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_SET    = 1'b1;

   typedef logic signed [POS_W-1:0] position_type;
   typedef logic        [DEG_W-1:0] degrees_type;
   typedef logic signed [1:0]       step_type;

   function automatic step_type step_dir(input logic [1:0] old_pair, input logic [1:0] new_pair);
      step_type dir;
      unique case ({old_pair, new_pair})
         4'b0010, 4'b0100, 4'b1101, 4'b1011: dir = 2'sd1;
         4'b0001, 4'b0111, 4'b1110, 4'b1000: dir = -2'sd1;
         default:                            dir = 2'sd0;
      endcase
      return dir;
   endfunction

endpackage

// File: hw/rtl/qdd_if.sv
interface qdd_req_if;
   import qdd_pkg::*;

   logic         valid;
   logic         ready;
   logic         opcode;
   logic         pin_a;
   logic         pin_b;
   position_type new_position;

   modport source (output valid, output opcode, output pin_a, output pin_b,
                   output new_position, input ready);
   modport sink   (input valid, input opcode, input pin_a, input pin_b,
                   input new_position, output ready);
endinterface

interface qdd_rsp_if;
   import qdd_pkg::*;

   logic         valid;
   logic         ready;
   position_type position_count;
   degrees_type  position_degrees;

   modport source (output valid, output position_count, output position_degrees,
                   input ready);
   modport sink   (input valid, input position_count, input position_degrees,
                   output ready);
endinterface

// File: hw/rtl/qdd_step.sv
module qdd_step
   import qdd_pkg::*;
#(
   parameter int unsigned STEPS_PER_DETENT = STEPS_PER_DETENT_DEF,
   parameter int unsigned DETENTS_PER_TURN = DETENTS_PER_TURN_DEF,
   localparam int unsigned AccW = $clog2(STEPS_PER_DETENT) + 2,
   localparam int unsigned CntW = ($clog2(DETENTS_PER_TURN) + 2 > 5) ?
                                  $clog2(DETENTS_PER_TURN) + 2 : 5
)(
   input  logic                   opcode,
   input  logic [1:0]             pins,
   input  position_type           new_position,
   input  logic [1:0]             prev_pins,
   input  logic signed [AccW-1:0] accum,
   input  logic signed [CntW-1:0] count,
   output logic [1:0]             prev_pins_nxt,
   output logic signed [AccW-1:0] accum_nxt,
   output logic signed [CntW-1:0] count_nxt
);

   localparam logic signed [AccW-1:0] AccHi = AccW'(STEPS_PER_DETENT);
   localparam logic signed [AccW-1:0] AccLo = -AccHi;
   localparam logic signed [CntW-1:0] CntHi = CntW'(DETENTS_PER_TURN);
   localparam logic signed [CntW-1:0] CntLo = -CntHi;

   step_type               dir;
   logic signed [AccW-1:0] acc_sum;
   logic signed [CntW-1:0] cnt_raw;

   always_comb begin
      dir     = step_dir(prev_pins, pins);
      acc_sum = accum + AccW'(dir);
      prev_pins_nxt = prev_pins;
      accum_nxt     = accum;
      cnt_raw       = count;
      if (opcode == OP_SET) begin
         cnt_raw = CntW'(new_position);
      end else begin
         prev_pins_nxt = pins;
         priority if (acc_sum >= AccHi) begin
            cnt_raw   = count - CntW'(1);
            accum_nxt = '0;
         end else if (acc_sum <= AccLo) begin
            cnt_raw   = count + CntW'(1);
            accum_nxt = '0;
         end else begin
            accum_nxt = acc_sum;
         end
      end
      if (cnt_raw >= CntHi || cnt_raw <= CntLo) begin
         count_nxt = '0;
      end else begin
         count_nxt = cnt_raw;
      end
   end

endmodule

// File: hw/rtl/quadrature_detent_decoder_unit.sv
// The response becomes valid in the cycle after the request transfer.
// Throughput: one item per cycle; the request side stalls only while a
// response is held and the response side is not ready.
// Reset (synchronous, active high): pins pair high, sub-step accumulator and
// detent count zero, no response pending.
module quadrature_detent_decoder_unit
   import qdd_pkg::*;
#(
   parameter int unsigned STEPS_PER_DETENT = STEPS_PER_DETENT_DEF,
   parameter int unsigned DETENTS_PER_TURN = DETENTS_PER_TURN_DEF
)(
   input logic        clock,
   input logic        reset,
   qdd_req_if.sink    req_ch,
   qdd_rsp_if.source  rsp_ch
);

   localparam int unsigned AccW = $clog2(STEPS_PER_DETENT) + 2;
   localparam int unsigned CntW = ($clog2(DETENTS_PER_TURN) + 2 > 5) ?
                                  $clog2(DETENTS_PER_TURN) + 2 : 5;
   localparam int unsigned MagW = $clog2(DETENTS_PER_TURN);

   logic                   take;
   logic [1:0]             prev_pins_ff, prev_pins_in;
   logic signed [AccW-1:0] accum_ff, accum_in;
   logic signed [CntW-1:0] count_ff, count_in;
   logic signed [CntW-1:0] mag;
   degrees_type            deg_table [DETENTS_PER_TURN];
   logic                   rsp_valid_ff;
   position_type           rsp_count_ff;
   degrees_type            rsp_degrees_ff;

   for (genvar i = 0; i < DETENTS_PER_TURN; i++) begin : g_deg
      localparam int unsigned DegVal = (i * DEG_PER_TURN) / DETENTS_PER_TURN;
      assign deg_table[i] = DEG_W'(DegVal);
   end

   qdd_step #(
      .STEPS_PER_DETENT (STEPS_PER_DETENT),
      .DETENTS_PER_TURN (DETENTS_PER_TURN)
   ) u_step (
      .opcode        (req_ch.opcode),
      .pins          ({req_ch.pin_b, req_ch.pin_a}),
      .new_position  (req_ch.new_position),
      .prev_pins     (prev_pins_ff),
      .accum         (accum_ff),
      .count         (count_ff),
      .prev_pins_nxt (prev_pins_in),
      .accum_nxt     (accum_in),
      .count_nxt     (count_in)
   );

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign mag          = (count_in < 0) ? -count_in : count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= PINS_AT_RESET;
         accum_ff     <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            prev_pins_ff <= prev_pins_in;
            accum_ff     <= accum_in;
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_count_ff   <= count_in[POS_W-1:0];
         rsp_degrees_ff <= deg_table[mag[MagW-1:0]];
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.position_count   = rsp_count_ff;
   assign rsp_ch.position_degrees = rsp_degrees_ff;

endmodule
